>>> rtl/glden_pkg.sv
// Shared types and constants of the Gaussian local density block.
// No dependencies; every other file but glden_ram imports this package.
package glden_pkg;

    localparam int DIST_W           = 32;
    localparam int PC_W             = 11;
    localparam int DENS_W           = 26;
    localparam int DEF_MAX_POINTS   = 1024;
    localparam int KERNEL_FRAC_BITS = 16;
    localparam int WORK_BITS        = 60;
    localparam int WW               = WORK_BITS + 1;
    localparam int ROUND_SHIFT      = WORK_BITS - KERNEL_FRAC_BITS - 1;
    localparam int KV_W             = WW - ROUND_SHIFT - 1;
    localparam int SERIES_TERMS     = 24;
    localparam int QUEUE_DEPTH      = 2;
    localparam int PROD_W           = 2 * DIST_W;
    localparam int P_W              = PROD_W - 16;
    localparam int PS_W             = 19;
    localparam int S_W              = 2 * PS_W - 16;
    localparam int ACC_W            = 2 * WW;

    localparam logic [P_W-1:0] P_LIMIT = P_W'(6 << 16);

    // configuration register indexes
    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_INV_CUTOFF  = 1'b1;

    // classification of one pair
    typedef struct packed {
        logic end_col;
        logic last_pair;
    } t_flags;

    // kernel unit status toward the back end
    typedef struct packed {
        logic            busy;
        logic            done;
        logic [KV_W-1:0] kv;
    } t_kstat;

endpackage

>>> rtl/gaussian_local_density.sv
// Top level of the Gaussian local density block: configuration registers,
// front end and back end. Depends on glden_pkg, glden_front and glden_back.
//
// Distances of a packed lower-triangle matrix stream in column by column; each
// pair adds exp(-(d*inv_cutoff)^2) in Q.16 to the density of both of its
// points, and a point's density is emitted (and its accumulator zeroed) when
// its column ends; the last pair of a set emits two points, the second with
// last_point set. The kernel unit forms the product and its square, sets up
// with k (0 to 31), the integer part of the squared scaled distance, then sums
// 24 Taylor terms of a Q1.60 exponential, each a multiply on a shared 32x32
// multiplier, a division in a four-bit-per-cycle divider and an add; it then
// scales by exp(-1) once per integer unit and rounds. A kernel that saturates
// to zero skips the series. The back end then reads and writes both
// accumulators in the density store, which has one write and one read port,
// emits each finished result, and only then takes the next item into the
// kernel. A two-entry queue sits between the front end and the back end, so
// input is still taken while a result waits, until the queue is full. After
// reset, and after every write of point_count, all MAX_POINTS entries of the
// store are swept to zero, during which input is stalled; exp(-1) is also
// computed once after reset. Configuration may only be written while the
// block is idle.
module gaussian_local_density import glden_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [DIST_W-1:0]             i_distance,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [$clog2(MAX_POINTS)-1:0] o_point_index,
    output logic [DENS_W-1:0]             o_density,
    output logic                          o_last_point,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [DIST_W-1:0]             i_cfg_data
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = (IW + 1 > PC_W) ? IW + 1 : PC_W;

    logic [PC_W-1:0]   r_point_count;
    logic [DIST_W-1:0] r_inv_cutoff;
    logic              cfg_wr, restart, clearing, pop, task_valid;
    logic [NW-1:0]     n_ext, n_act;
    logic [IW-1:0]     nlast, col, row;
    logic [DIST_W-1:0] distance;
    t_flags            flags;
    t_kstat            kstat;

    // config port never stalls
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    // a point_count write restarts the set, even with the same value
    assign restart     = cfg_wr && (i_cfg_index == CFG_POINT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= PC_W'(2);
            r_inv_cutoff  <= DIST_W'(65536);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_POINT_COUNT: r_point_count <= i_cfg_data[PC_W-1:0];
                CFG_INV_CUTOFF:  r_inv_cutoff  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the point count into range, then take the last index
    always_comb begin
        n_ext = NW'(r_point_count);
        if (n_ext < NW'(2)) begin
            n_act = NW'(2);
        end else if (n_ext > NW'(MAX_POINTS)) begin
            n_act = NW'(MAX_POINTS);
        end else begin
            n_act = n_ext;
        end
        nlast = IW'(n_act - NW'(1));
    end

    glden_front #(.IW(IW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_hold       (clearing),
        .i_nlast      (nlast),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_distance   (i_distance),
        .i_pop        (pop),
        .o_task_valid (task_valid),
        .o_distance   (distance),
        .o_col        (col),
        .o_row        (row),
        .o_flags      (flags)
    );

    glden_back #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (restart),
        .i_inv_cutoff  (r_inv_cutoff),
        .o_clearing    (clearing),
        .i_task_valid  (task_valid),
        .o_pop         (pop),
        .i_distance    (distance),
        .i_col         (col),
        .i_row         (row),
        .i_flags       (flags),
        .o_kstat       (kstat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_point_index (o_point_index),
        .o_density     (o_density),
        .o_last_point  (o_last_point)
    );

    // no input may slip in while the store is being swept
    a_hold_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> o_in_stall)
        else $error("input accepted during store sweep");

    // the closing result of a set always belongs to the last point
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_point) |-> (o_point_index == nlast))
        else $error("last result carries the wrong point index");

    // a kernel value never exceeds one in Q.16
    a_kernel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kstat.done |-> (kstat.kv <= KV_W'(65536)))
        else $error("kernel value out of range");
endmodule

>>> rtl/glden_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glden_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/glden_front.sv
// Front end: accept distances, tag each with its pair position, and queue them.
// Depends on glden_pkg.
module glden_front import glden_pkg::*; #(
    parameter int IW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic              i_hold,
    input  logic [IW-1:0]     i_nlast,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DIST_W-1:0] i_distance,
    input  logic              i_pop,
    output logic              o_task_valid,
    output logic [DIST_W-1:0] o_distance,
    output logic [IW-1:0]     o_col,
    output logic [IW-1:0]     o_row,
    output t_flags            o_flags
);
    localparam int TW  = DIST_W + 2 * IW + 2;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [IW-1:0]  r_col, r_row;
    logic [TW-1:0]  r_q [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           push, pop, full;
    t_flags         flags;

    always_comb begin
        flags.end_col   = (r_row == i_nlast);
        flags.last_pair = (r_row == i_nlast) && (r_col == i_nlast - IW'(1));
    end

    assign full       = (r_cnt == (QAW+1)'(QUEUE_DEPTH));
    assign o_in_stall = full || i_hold;
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= IW'(1);
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= {i_distance, r_col, r_row, flags};
                r_wp <= (r_wp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QAW'(1);
                // advance the pair position
                if (flags.last_pair) begin
                    r_col <= '0;
                    r_row <= IW'(1);
                end else if (flags.end_col) begin
                    r_col <= r_col + IW'(1);
                    r_row <= r_col + IW'(2);
                end else begin
                    r_row <= r_row + IW'(1);
                end
            end
            if (pop) begin
                r_rp <= (r_rp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    assign o_task_valid = (r_cnt != '0);
    assign {o_distance, o_col, o_row, o_flags} = r_q[r_rp];
endmodule

>>> rtl/glden_kernel.sv
// Kernel unit: round(2^16 * exp(-s)) by a Q1.60 Taylor series on a shared
// 32x32 multiplier and a radix-16 divider. Depends on glden_pkg.
module glden_kernel import glden_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIST_W-1:0] i_distance,
    input  logic [DIST_W-1:0] i_inv_cutoff,
    output t_kstat            o_stat
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PROD  = 8'b0000_0010,
        S_SQR   = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_SUM   = 8'b0010_0000,
        S_ROUND = 8'b0100_0000,
        S_ZERO  = 8'b1000_0000
    } t_state;

    localparam logic [WW-1:0] ONE = WW'(1) << WORK_BITS;

    t_state           r_state;
    logic             r_init, r_scale, r_done;
    logic [PROD_W-1:0] r_prod;
    logic [S_W-1:0]   r_s;
    logic [WW-1:0]    r_term, r_sum, r_y, r_e1, r_ma, r_mb;
    logic [4:0]       r_n;
    logic [5:0]       r_k;
    logic [ACC_W-1:0] r_acc;
    logic [1:0]       r_mcnt;
    logic [63:0]      r_dvd;
    logic [4:0]       r_rem;
    logic [3:0]       r_dcnt;
    logic [KV_W-1:0]  r_kv;

    logic [31:0]       a_part, b_part;
    logic [63:0]       pp;
    logic [ACC_W-1:0]  n_acc;
    logic [WW-1:0]     mres, n_sum, y_new;
    logic [63:0]       n_dvd;
    logic [4:0]        n_rem;
    logic [P_W-1:0]    p;
    logic [2*PS_W-1:0] sq;
    logic [KV_W:0]     rnd;

    // one partial product per cycle
    always_comb begin
        a_part = r_mcnt[1] ? 32'(r_ma[WW-1:32]) : r_ma[31:0];
        b_part = r_mcnt[0] ? 32'(r_mb[WW-1:32]) : r_mb[31:0];
        pp     = a_part * b_part;
        case (r_mcnt) inside
            2'd0:       n_acc = r_acc + ACC_W'(pp);
            2'd1, 2'd2: n_acc = r_acc + (ACC_W'(pp) << 32);
            default:    n_acc = r_acc + (ACC_W'(pp) << 64);
        endcase
        mres = n_acc[WW+WORK_BITS-1:WORK_BITS];
    end

    // four quotient bits per cycle; divisor is the term number
    always_comb begin
        logic [5:0] t;
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int i = 0; i < 4; i++) begin
            t = {n_rem, n_dvd[63]};
            if (t >= {1'b0, r_n}) begin
                n_rem = 5'(t - {1'b0, r_n});
                n_dvd = {n_dvd[62:0], 1'b1};
            end else begin
                n_rem = t[4:0];
                n_dvd = {n_dvd[62:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_n[0]) begin
            n_sum = (r_sum >= r_term) ? r_sum - r_term : '0;
        end else begin
            n_sum = r_sum + r_term;
        end
        p     = r_prod[PROD_W-1:16];
        sq    = p[PS_W-1:0] * p[PS_W-1:0];
        y_new = {1'b0, r_s[15:0], 44'b0};
        rnd   = r_sum[WW-1:ROUND_SHIFT] + (KV_W+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            // compute exp(-1) once after reset
            r_state <= S_MUL;
            r_init  <= 1'b1;
            r_scale <= 1'b0;
            r_term  <= ONE;
            r_sum   <= ONE;
            r_y     <= ONE;
            r_ma    <= ONE;
            r_mb    <= ONE;
            r_n     <= 5'd1;
            r_k     <= '0;
            r_acc   <= '0;
            r_mcnt  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_prod  <= i_distance * i_inv_cutoff;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_s     <= S_W'(sq >> 16);
                    r_state <= (p >= P_LIMIT) ? S_ZERO : S_SQR;
                end
                S_SQR: begin
                    if (r_s[S_W-1]) begin
                        r_state <= S_ZERO;
                    end else begin
                        r_k     <= 6'(r_s[S_W-1:16]);
                        r_term  <= ONE;
                        r_sum   <= ONE;
                        r_y     <= y_new;
                        r_ma    <= ONE;
                        r_mb    <= y_new;
                        r_n     <= 5'd1;
                        r_scale <= 1'b0;
                        r_acc   <= '0;
                        r_mcnt  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc  <= n_acc;
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd3) begin
                        if (!r_scale) begin
                            r_dvd   <= 64'(mres);
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_sum <= mres;
                            r_k   <= r_k - 6'd1;
                            r_ma  <= mres;
                            r_acc <= '0;
                            if (r_k == 6'd1) begin
                                r_state <= S_ROUND;
                            end
                        end
                    end
                end
                S_DIV: begin
                    r_dvd  <= n_dvd;
                    r_rem  <= n_rem;
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd15) begin
                        r_term  <= n_dvd[WW-1:0];
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sum  <= n_sum;
                    r_acc  <= '0;
                    r_mcnt <= '0;
                    if (r_n == 5'(SERIES_TERMS)) begin
                        if (r_init) begin
                            r_e1    <= n_sum;
                            r_init  <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (r_k == '0) begin
                            r_state <= S_ROUND;
                        end else begin
                            r_ma    <= n_sum;
                            r_mb    <= r_e1;
                            r_scale <= 1'b1;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_n     <= r_n + 5'd1;
                        r_ma    <= r_term;
                        r_mb    <= r_y;
                        r_state <= S_MUL;
                    end
                end
                S_ROUND: begin
                    r_kv    <= rnd[KV_W:1];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_ZERO: begin
                    r_kv    <= '0;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = r_done;
    assign o_stat.kv   = r_kv;
endmodule

>>> rtl/glden_back.sv
// Back end: run the kernel, update both accumulators, emit finished points.
// Depends on glden_pkg, glden_kernel and glden_ram.
module glden_back import glden_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int IW         = $clog2(MAX_POINTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic [DIST_W-1:0] i_inv_cutoff,
    output logic              o_clearing,
    input  logic              i_task_valid,
    output logic              o_pop,
    input  logic [DIST_W-1:0] i_distance,
    input  logic [IW-1:0]     i_col,
    input  logic [IW-1:0]     i_row,
    input  t_flags            i_flags,
    output t_kstat            o_kstat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [IW-1:0]     o_point_index,
    output logic [DENS_W-1:0] o_density,
    output logic              o_last_point
);
    typedef enum logic [7:0] {
        B_CLEAR = 8'b0000_0001,
        B_IDLE  = 8'b0000_0010,
        B_WAIT  = 8'b0000_0100,
        B_RDROW = 8'b0000_1000,
        B_RDCOL = 8'b0001_0000,
        B_WRCOL = 8'b0010_0000,
        B_EMITC = 8'b0100_0000,
        B_EMITR = 8'b1000_0000
    } t_state;

    t_state            r_state;
    logic [IW-1:0]     r_clr, r_col, r_row;
    t_flags            r_flags;
    logic [KV_W-1:0]   r_kv;
    logic [DENS_W-1:0] r_row_sum, r_col_sum;
    logic              r_out_valid, r_last;
    logic [IW-1:0]     r_idx;
    logic [DENS_W-1:0] r_dens;

    t_kstat            kstat;
    logic              start, we, out_free;
    logic [IW-1:0]     waddr, raddr;
    logic [DENS_W-1:0] wdata, rdata, sum;

    assign start    = (r_state == B_IDLE) && i_task_valid && !kstat.busy;
    assign o_pop    = start;
    assign out_free = !r_out_valid || !i_out_stall;
    assign sum      = rdata + DENS_W'(r_kv);

    glden_kernel u_kernel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_distance   (i_distance),
        .i_inv_cutoff (i_inv_cutoff),
        .o_stat       (kstat)
    );

    always_comb begin
        we    = 1'b0;
        waddr = r_row;
        wdata = '0;
        raddr = r_row;
        unique case (r_state)
            B_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
            end
            B_RDCOL: begin
                we    = 1'b1;
                wdata = r_flags.last_pair ? '0 : sum;
                raddr = r_col;
            end
            B_WRCOL: begin
                we    = 1'b1;
                waddr = r_col;
                wdata = r_flags.end_col ? '0 : sum;
            end
            default: ;
        endcase
    end

    glden_ram #(.WIDTH(DENS_W), .DEPTH(MAX_POINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(MAX_POINTS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (start) begin
                        r_col   <= i_col;
                        r_row   <= i_row;
                        r_flags <= i_flags;
                        r_state <= B_WAIT;
                    end
                end
                B_WAIT: begin
                    if (kstat.done) begin
                        r_kv    <= kstat.kv;
                        r_state <= B_RDROW;
                    end
                end
                B_RDROW: r_state <= B_RDCOL;
                B_RDCOL: begin
                    r_row_sum <= sum;
                    r_state   <= B_WRCOL;
                end
                B_WRCOL: begin
                    r_col_sum <= sum;
                    r_state   <= r_flags.end_col ? B_EMITC : B_IDLE;
                end
                B_EMITC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_idx       <= r_col;
                        r_dens      <= r_col_sum;
                        r_last      <= 1'b0;
                        r_state     <= r_flags.last_pair ? B_EMITR : B_IDLE;
                    end
                end
                B_EMITR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_idx       <= r_row;
                        r_dens      <= r_row_sum;
                        r_last      <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_clearing    = (r_state == B_CLEAR);
    assign o_kstat       = kstat;
    assign o_out_valid   = r_out_valid;
    assign o_point_index = r_idx;
    assign o_density     = r_dens;
    assign o_last_point  = r_last;
endmodule
